// ----- hw/rtl/spin_feedforward_torque_assert.svh -----
// assertion macros for the spin feed-forward torque block
// expects a clock named clk and an active-low reset named rst_n in the including module
`ifndef SPIN_FEEDFORWARD_TORQUE_ASSERT_SVH
`define SPIN_FEEDFORWARD_TORQUE_ASSERT_SVH

// same-cycle implication
`define SFFT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFFT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/sfft_pkg.sv -----
// constants for the spin feed-forward torque block
// no dependencies
`default_nettype none

package sfft_pkg;

  // item kinds
  localparam logic [1:0] OP_CMD     = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_PROTECT = 2'd2;

  // register indexes (byte address 4*i)
  localparam logic [2:0] REG_TIMEOUT  = 3'd0;
  localparam logic [2:0] REG_FRONT    = 3'd1;
  localparam logic [2:0] REG_REAR     = 3'd2;
  localparam logic [2:0] REG_MAXTRQ   = 3'd3;
  localparam logic [2:0] REG_SIGN     = 3'd4;

  // fixed-point constants
  localparam logic signed [15:0] SPEED_LIM  = 16'sd16000;
  localparam logic signed [15:0] PHASE_LIM  = 16'sd16384;
  localparam logic [23:0]        SPEED_ALPHA = 24'd3277;
  localparam logic [56:0]        NORM_MIN_SQ = 57'd175921860444;
  localparam logic signed [17:0] ONE_Q16    = 18'sd65536;
  localparam logic signed [23:0] ONE_Q22    = 24'sd4194304;

endpackage

`default_nettype wire

// ----- hw/rtl/spin_feedforward_torque.sv -----
// spin feed-forward torque: command filter, norm, gain blend and saturation
// depends on sfft_pkg and spin_feedforward_torque_assert.svh
`default_nettype none

// Takes one item at a time. Commands, protect clears, unused kinds and
// inactive ticks go to the done state and raise out_tvalid once the
// output register is free. An active tick runs through a shared
// bit-serial shift-add multiplier (for the speed filter, the two squares,
// the gain blend and the torque product), a one-bit-per-cycle square root
// and a one-bit-per-cycle divider, then raises out_tvalid once the output
// register is free; a phase vector too short to normalize skips the root
// and the divider. The sequencer goes idle in the same cycle the result loads.
// in_tready is high whenever no item is in progress; a finished result
// waits in the output register while the next item is taken in.

`include "spin_feedforward_torque_assert.svh"

module spin_feedforward_torque
  import sfft_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  // input channel
  input  wire         in_tvalid,
  output logic        in_tready,
  // spin_speed[15:0], spin_enable[16], phase_sine[32:17], phase_cosine[48:33],
  // now_ms[80:49], zero fill [87:81]
  input  wire  [87:0] in_tdata,
  // op[1:0]
  input  wire  [1:0]  in_tuser,
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  // torque[23:0], rear_weight[40:24], zero fill [47:41]
  output logic [47:0] out_tdata,
  // active[0]
  output logic [0:0]  out_tuser,
  // configuration port
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [4:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NW = (TIME_BITS < 32) ? TIME_BITS : 32;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SPDM = 4'd1;
  localparam logic [3:0] S_SPDF = 4'd2;
  localparam logic [3:0] S_SQS  = 4'd3;
  localparam logic [3:0] S_SQC  = 4'd4;
  localparam logic [3:0] S_NORM = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_WGT  = 4'd8;
  localparam logic [3:0] S_GNM  = 4'd9;
  localparam logic [3:0] S_GNF  = 4'd10;
  localparam logic [3:0] S_TQM  = 4'd11;
  localparam logic [3:0] S_TQF  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  // configuration registers
  logic [15:0] timeout_r;
  logic [23:0] front_r;
  logic [23:0] rear_r;
  logic [22:0] maxtrq_r;
  logic        signneg_r;

  // block state
  logic signed [15:0] speed_goal_r, sine_goal_r, cos_goal_r;
  logic signed [31:0] spd_s_r;
  logic signed [23:0] sin_s_r, cos_s_r;
  logic               spin_on_r;
  logic [TIME_BITS-1:0] last_r;
  logic signed [23:0] torque_held_r;
  logic [16:0]        weight_held_r;

  // sequencer and datapath
  logic [3:0]  state_r;
  logic [5:0]  cnt_r;
  logic [56:0] mul_a_r, acc_r;
  logic [23:0] mul_b_r;
  logic        neg_r;
  logic [45:0] sq_v_r;
  logic [25:0] sq_rem_r;
  logic [22:0] root_r;
  logic [38:0] div_n_r;
  logic [23:0] div_r_r;
  logic signed [17:0] ncos_r;
  logic [16:0] w_r;
  logic signed [23:0] res_t_r;
  logic [16:0] res_w_r;
  logic        res_a_r;

  // output register
  logic        out_valid_r;
  logic signed [23:0] out_t_r;
  logic [16:0] out_w_r;
  logic        out_a_r;

  // one-step phase low-pass, alpha one quarter
  function automatic logic signed [23:0] lp_phase(logic signed [15:0] g,
                                                  logic signed [23:0] s);
    logic signed [24:0] d;
    logic [24:0] mag;
    logic [24:0] r;
    d   = 25'(signed'({g, 8'b0})) - 25'(s);
    mag = d[24] ? 25'(-d) : 25'(d);
    r   = (mag + 25'd2) >> 2;
    return d[24] ? 24'(s - signed'(r[23:0])) : 24'(s + signed'(r[23:0]));
  endfunction

  // symmetric clamp of a 16-bit value
  function automatic logic signed [15:0] clamp16(logic signed [15:0] x,
                                                 logic signed [15:0] lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  // input decode
  logic signed [15:0] spd_c, sn_c, cs_c;
  logic               en_in;
  logic [TIME_BITS-1:0] now_t, age;
  logic               tick_ok;
  assign spd_c   = clamp16(signed'(in_tdata[15:0]), SPEED_LIM);
  assign en_in   = in_tdata[16];
  assign sn_c    = clamp16(signed'(in_tdata[32:17]), PHASE_LIM);
  assign cs_c    = clamp16(signed'(in_tdata[48:33]), PHASE_LIM);
  assign now_t   = TIME_BITS'(in_tdata[49 +: NW]);
  assign age     = now_t - last_r;
  assign tick_ok = spin_on_r && (age <= TIME_BITS'(timeout_r));

  // speed filter error
  logic signed [32:0] spd_d;
  assign spd_d = 33'(signed'({speed_goal_r, 16'b0})) - 33'(spd_s_r);

  // multiplier step
  logic [56:0] acc_step;
  assign acc_step = acc_r + (mul_b_r[0] ? mul_a_r : 57'd0);

  // square root step
  logic [25:0] rem2, trial;
  logic        sq_ge;
  logic [25:0] rem_step;
  logic [22:0] root_step;
  assign rem2      = {sq_rem_r[23:0], sq_v_r[45:44]};
  assign trial     = {1'b0, root_r, 2'b01};
  assign sq_ge     = rem2 >= trial;
  assign rem_step  = sq_ge ? rem2 - trial : rem2;
  assign root_step = {root_r[21:0], sq_ge};

  // divider step
  logic [23:0] dr2;
  logic        dv_ge;
  logic [38:0] n_step;
  assign dr2    = {div_r_r[22:0], div_n_r[38]};
  assign dv_ge  = dr2 >= {1'b0, root_r};
  assign n_step = {div_n_r[37:0], dv_ge};

  // magnitudes of the filtered values
  logic [22:0] sin_mag, cos_mag;
  logic [31:0] spd_mag;
  assign sin_mag = sin_s_r[23] ? 23'(-sin_s_r) : 23'(sin_s_r);
  assign cos_mag = cos_s_r[23] ? 23'(-cos_s_r) : 23'(cos_s_r);
  assign spd_mag = spd_s_r[31] ? 32'(-spd_s_r) : 32'(spd_s_r);

  // rounded product tails
  logic [56:0] rnd16, rnd28;
  assign rnd16 = (acc_r + 57'd32768) >> 16;
  assign rnd28 = (acc_r + 57'd134217728) >> 28;

  // finishing arithmetic
  logic signed [31:0] spd_new;
  logic [38:0]        q_cl;
  logic signed [17:0] ncos_div;
  logic signed [18:0] w_full;
  logic signed [24:0] gdiff;
  logic [23:0]        gain;
  logic [22:0]        tq_lim;
  logic signed [23:0] tq;
  assign spd_new  = neg_r ? spd_s_r - signed'(rnd16[31:0]) : spd_s_r + signed'(rnd16[31:0]);
  assign q_cl     = (n_step > 39'd65536) ? 39'd65536 : n_step;
  assign ncos_div = cos_s_r[23] ? -signed'(q_cl[17:0]) : signed'(q_cl[17:0]);
  assign w_full   = (19'sd65537 - 19'(ncos_r)) >>> 1;
  assign gdiff    = signed'({1'b0, rear_r}) - signed'({1'b0, front_r});
  assign gain     = neg_r ? front_r - rnd16[23:0] : front_r + rnd16[23:0];
  assign tq_lim   = (rnd28 > 57'(maxtrq_r)) ? maxtrq_r : rnd28[22:0];
  assign tq       = neg_r ? -signed'({1'b0, tq_lim}) : signed'({1'b0, tq_lim});

  // the sine square hands the multiplier over to the cosine square
  logic sq_switch;
  assign sq_switch = (state_r == S_SQS) && (cnt_r == 6'd0);

  assign in_tready = (state_r == S_IDLE);

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      speed_goal_r  <= '0;
      sine_goal_r   <= '0;
      cos_goal_r    <= PHASE_LIM;
      spd_s_r       <= '0;
      sin_s_r       <= '0;
      cos_s_r       <= ONE_Q22;
      spin_on_r     <= 1'b0;
      last_r        <= '0;
      torque_held_r <= '0;
      weight_held_r <= '0;
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_DONE) out_valid_r <= 1'b0;

      // shared multiplier advances in every multiply state
      if (state_r == S_SPDM || state_r == S_SQS || state_r == S_SQC ||
          state_r == S_GNM || state_r == S_TQM) begin
        acc_r <= acc_step;
        if (sq_switch) begin
          // keep the accumulator so the two squares sum
          mul_a_r <= 57'(cos_mag);
          mul_b_r <= 24'(cos_mag);
          cnt_r   <= 6'd22;
        end else begin
          mul_a_r <= mul_a_r << 1;
          mul_b_r <= mul_b_r >> 1;
          cnt_r   <= cnt_r - 6'd1;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            case (in_tuser)
              OP_CMD: begin
                state_r      <= S_DONE;
                speed_goal_r <= en_in ? spd_c : '0;
                sine_goal_r  <= en_in ? sn_c : '0;
                cos_goal_r   <= en_in ? cs_c : PHASE_LIM;
                spin_on_r    <= en_in;
                last_r       <= now_t;
                res_a_r      <= en_in;
                if (!en_in) begin
                  spd_s_r       <= '0;
                  torque_held_r <= '0;
                  weight_held_r <= '0;
                  res_t_r       <= '0;
                  res_w_r       <= '0;
                end else begin
                  res_t_r <= torque_held_r;
                  res_w_r <= weight_held_r;
                end
              end
              OP_TICK: begin
                res_a_r <= 1'b0;
                res_t_r <= '0;
                res_w_r <= '0;
                if (!tick_ok) begin
                  spd_s_r       <= '0;
                  torque_held_r <= '0;
                  weight_held_r <= '0;
                  state_r       <= S_DONE;
                end else begin
                  sin_s_r <= lp_phase(sine_goal_r, sin_s_r);
                  cos_s_r <= lp_phase(cos_goal_r, cos_s_r);
                  mul_a_r <= 57'(spd_d[32] ? 33'(-spd_d) : 33'(spd_d));
                  mul_b_r <= SPEED_ALPHA;
                  acc_r   <= '0;
                  neg_r   <= spd_d[32];
                  cnt_r   <= 6'd11;
                  state_r <= S_SPDM;
                end
              end
              OP_PROTECT: begin
                state_r       <= S_DONE;
                spd_s_r       <= '0;
                torque_held_r <= '0;
                weight_held_r <= '0;
                res_a_r       <= 1'b0;
                res_t_r       <= '0;
                res_w_r       <= '0;
              end
              default: begin
                state_r <= S_DONE;
                res_a_r <= 1'b0;
                res_t_r <= torque_held_r;
                res_w_r <= weight_held_r;
              end
            endcase
          end
        end
        S_SPDM: begin
          if (cnt_r == 6'd0) state_r <= S_SPDF;
        end
        S_SPDF: begin
          spd_s_r <= spd_new;
          mul_a_r <= 57'(sin_mag);
          mul_b_r <= 24'(sin_mag);
          acc_r   <= '0;
          cnt_r   <= 6'd22;
          state_r <= S_SQS;
        end
        S_SQS: begin
          if (cnt_r == 6'd0) state_r <= S_SQC;
        end
        S_SQC: begin
          if (cnt_r == 6'd0) state_r <= S_NORM;
        end
        S_NORM: begin
          if (acc_r > NORM_MIN_SQ) begin
            sq_v_r   <= acc_r[45:0];
            sq_rem_r <= '0;
            root_r   <= '0;
            cnt_r    <= 6'd22;
            state_r  <= S_SQRT;
          end else begin
            ncos_r  <= ONE_Q16;
            state_r <= S_WGT;
          end
        end
        S_SQRT: begin
          sq_rem_r <= rem_step;
          root_r   <= root_step;
          sq_v_r   <= sq_v_r << 2;
          if (cnt_r == 6'd0) begin
            div_n_r <= {cos_mag, 16'b0} + 39'(root_step >> 1);
            div_r_r <= '0;
            cnt_r   <= 6'd38;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_DIV: begin
          div_r_r <= dv_ge ? dr2 - {1'b0, root_r} : dr2;
          div_n_r <= n_step;
          if (cnt_r == 6'd0) begin
            ncos_r  <= ncos_div;
            state_r <= S_WGT;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        S_WGT: begin
          w_r     <= w_full[16:0];
          mul_a_r <= {33'b0, 24'(gdiff[24] ? -gdiff : gdiff)};
          mul_b_r <= 24'(w_full[16:0]);
          acc_r   <= '0;
          neg_r   <= gdiff[24];
          cnt_r   <= 6'd16;
          state_r <= S_GNM;
        end
        S_GNM: begin
          if (cnt_r == 6'd0) state_r <= S_GNF;
        end
        S_GNF: begin
          mul_a_r <= 57'(spd_mag);
          mul_b_r <= gain;
          acc_r   <= '0;
          neg_r   <= spd_s_r[31] ^ signneg_r;
          cnt_r   <= 6'd23;
          state_r <= S_TQM;
        end
        S_TQM: begin
          if (cnt_r == 6'd0) state_r <= S_TQF;
        end
        S_TQF: begin
          torque_held_r <= tq;
          weight_held_r <= w_r;
          res_t_r       <= tq;
          res_w_r       <= w_r;
          res_a_r       <= 1'b1;
          state_r       <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_t_r     <= res_t_r;
            out_w_r     <= res_w_r;
            out_a_r     <= res_a_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_w_r, out_t_r};
  assign out_tuser  = out_a_r;

  // configuration writes
  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 16'd100;
      front_r   <= '0;
      rear_r    <= '0;
      maxtrq_r  <= 23'd65536;
      signneg_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_TIMEOUT: timeout_r <= cfg_pwdata[15:0];
        REG_FRONT:   front_r   <= cfg_pwdata[23:0];
        REG_REAR:    rear_r    <= cfg_pwdata[23:0];
        REG_MAXTRQ:  maxtrq_r  <= cfg_pwdata[22:0];
        REG_SIGN:    signneg_r <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_TIMEOUT: cfg_prdata = {16'b0, timeout_r};
      REG_FRONT:   cfg_prdata = {8'b0, front_r};
      REG_REAR:    cfg_prdata = {8'b0, rear_r};
      REG_MAXTRQ:  cfg_prdata = {9'b0, maxtrq_r};
      REG_SIGN:    cfg_prdata = {31'b0, signneg_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // checks
  `SFFT_ASSERT_NXT(a_accept_busy, in_tvalid && in_tready, state_r != S_IDLE,
                   "transfer accepted but sequencer stayed idle")
  `SFFT_ASSERT_NXT(a_done_holds, state_r == S_DONE && out_valid_r && !out_tready,
                   state_r == S_DONE, "result overwrote a pending output")
  `SFFT_ASSERT_NOW(a_weight_range, out_valid_r, out_w_r <= 17'd65536,
                   "rear weight above one")
  `SFFT_ASSERT_NOW(a_spd_count, state_r == S_SPDM, cnt_r <= 6'd11,
                   "speed multiply ran past its bit count")

endmodule

`default_nettype wire
